FILE: rtl/core/rlip_pkg.sv
// ----------------------------------------------------------------------------
// Ray line integral projector package
// Shared constants, types and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rlip_pkg;

  localparam int GridSize    = 256;
  localparam int AddrBits    = 8;
  localparam int DensityBits = 16;
  localparam int TotalBits   = 26;
  localparam int OrgBits     = 24;
  localparam int DirBits     = 16;
  // Slab parameter width: |(bound - origin) * 2^14| < 2^39.
  localparam int NumBits     = 40;
  localparam int TBits       = 41;
  // Sample position origin*2^14 + t*dir fits in 58 bits.
  localparam int PosBits     = 60;

  localparam logic [TotalBits-1:0] TotalMax = '1;
  localparam logic [TBits-1:0]     HalfStep = TBits'(2048);

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdTrace = 1'b1;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StSlab  = 8'b0000_0010,
    StDiv   = 8'b0000_0100,
    StMerge = 8'b0000_1000,
    StCheck = 8'b0001_0000,
    StPos   = 8'b0010_0000,
    StRead  = 8'b0100_0000,
    StAcc   = 8'b1000_0000
  } state_e;

endpackage

FILE: rtl/core/ray_line_integral_projector_core.sv
// ----------------------------------------------------------------------------
// Ray line integral projector core
// Writes density cells, or clips a ray to the grid square and sums the cell
// densities sampled every half cell along it.
// ----------------------------------------------------------------------------
// A write is done while the core stays idle. A trace runs its 4 slab divisions
// through one shared restoring divider and then a merge, then steps through the
// half-cell samples (check, position, read, accumulate) and a final check. A miss
// ends after the merge. busy is high while a trace runs; one result strobe per
// trace, none per write. The receiver cannot stall the result. Reset is
// asynchronous and restores image_size to 256; the density memory is not cleared.
module ray_line_integral_projector_core import rlip_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we_i,
  input  logic [8:0]                 cfg_wdata_i,
  input  logic                       command_i,
  input  logic [7:0]                 cell_x_i,
  input  logic [7:0]                 cell_y_i,
  input  logic [15:0]                cell_density_i,
  input  logic signed [OrgBits-1:0]  origin_x_i,
  input  logic signed [OrgBits-1:0]  origin_y_i,
  input  logic signed [DirBits-1:0]  dir_x_i,
  input  logic signed [DirBits-1:0]  dir_y_i,
  output logic                       done_o,
  output logic [TotalBits-1:0]       total_density_o,
  output logic                       ray_hit_o
);

  logic [DensityBits-1:0] mem_q [GridSize*GridSize];
  logic [DensityBits-1:0] rd_q;

  state_e state_q, state_d;
  logic [8:0] size_q;
  logic [8:0] sz_q;
  logic signed [OrgBits-1:0] ox_q, oy_q;
  logic signed [DirBits-1:0] dx_q, dy_q;
  logic [1:0] sidx_q;           // slab index: bit1 = axis, bit0 = bound
  logic signed [TBits-1:0] tb_q [4];
  logic [5:0] dcnt_q;
  logic [DirBits-1:0] rem_q;
  logic [NumBits-1:0] quo_q;
  logic [DirBits-1:0] dmag_q;
  logic neg_q;
  logic stat_q;
  logic signed [TBits-1:0] t_q, exit_q;
  logic signed [PosBits-1:0] px_q, py_q;
  logic [TotalBits:0] total_q;
  logic inb_q;
  logic done_q, hit_q;
  logic [TotalBits-1:0] res_q;

  assign busy = (state_q != StIdle);
  assign done_o = done_q;
  assign total_density_o = res_q;
  assign ray_hit_o = hit_q;

  wire [9:0] szc = (size_q > 9'(GridSize)) ? 10'(GridSize) : {1'b0, size_q};

  // Numerator of the current slab: (bound - origin) * 2^14.
  logic signed [OrgBits+1:0] org_a, bnd_a, diff_a;
  logic signed [DirBits-1:0] dir_a;
  always_comb begin
    org_a  = sidx_q[1] ? (OrgBits+2)'(oy_q) : (OrgBits+2)'(ox_q);
    dir_a  = sidx_q[1] ? dy_q : dx_q;
    bnd_a  = sidx_q[0] ? $signed({5'b0, sz_q, 12'b0}) : '0;
    diff_a = bnd_a - org_a;
  end

  wire signed [NumBits-1:0] num_a = NumBits'(diff_a) <<< 14;
  wire [NumBits-1:0] nmag = num_a[NumBits-1] ? NumBits'(-num_a) : NumBits'(num_a);
  wire [DirBits-1:0] dmag = dir_a[DirBits-1] ? DirBits'(-dir_a) : DirBits'(dir_a);

  // One restoring step: shift remainder/quotient pair left and try subtract.
  wire [DirBits:0] rtry = {rem_q, quo_q[NumBits-1]};
  wire sub_ok = rtry >= {1'b0, dmag_q};
  wire [DirBits:0] rnew = sub_ok ? rtry - {1'b0, dmag_q} : rtry;

  logic signed [TBits-1:0] lo_x, hi_x, lo_y, hi_y, ent_c, ext_c;
  always_comb begin
    lo_x = (tb_q[0] < tb_q[1]) ? tb_q[0] : tb_q[1];
    hi_x = (tb_q[0] < tb_q[1]) ? tb_q[1] : tb_q[0];
    lo_y = (tb_q[2] < tb_q[3]) ? tb_q[2] : tb_q[3];
    hi_y = (tb_q[2] < tb_q[3]) ? tb_q[3] : tb_q[2];
    if (dx_q == '0) begin
      ent_c = lo_y; ext_c = hi_y;
    end else if (dy_q == '0) begin
      ent_c = lo_x; ext_c = hi_x;
    end else begin
      ent_c = (lo_x > lo_y) ? lo_x : lo_y;
      ext_c = (hi_x < hi_y) ? hi_x : hi_y;
    end
  end

  wire oxo = (ox_q < 0) || (OrgBits+2)'(ox_q) > $signed({5'b0, sz_q, 12'b0});
  wire oyo = (oy_q < 0) || (OrgBits+2)'(oy_q) > $signed({5'b0, sz_q, 12'b0});

  // Step products t * dir, 41 by 16 bits.
  wire signed [TBits+DirBits-1:0] mx = t_q * dx_q;
  wire signed [TBits+DirBits-1:0] my = t_q * dy_q;

  // Cell index is the floor of the position over 2^26.
  wire signed [PosBits-27:0] cx = px_q[PosBits-1:26];
  wire signed [PosBits-27:0] cy = py_q[PosBits-1:26];
  wire cin = (cx >= 0) && (cy >= 0) &&
             (cx < $signed((PosBits-26)'(sz_q))) && (cy < $signed((PosBits-26)'(sz_q)));

  wire [TotalBits:0] sum = total_q + (TotalBits+1)'(inb_q ? rd_q : '0);

  always_ff @(posedge clk_i) begin
    if (start && !busy && command_i == CmdWrite) begin
      mem_q[{cell_y_i, cell_x_i}] <= cell_density_i;
    end
    rd_q <= mem_q[{cy[AddrBits-1:0], cx[AddrBits-1:0]}];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start && command_i == CmdTrace) state_d = StSlab;
      StSlab:  state_d = StDiv;
      StDiv:   if (dcnt_q == '0) state_d = (sidx_q == 2'd3) ? StMerge : StSlab;
      StMerge: state_d = StIdle;
      StCheck: begin
        if (stat_q) begin
          state_d = StIdle;
        end else begin
          state_d = (t_q < exit_q && total_q < (TotalBits+1)'(TotalMax)) ? StPos : StIdle;
        end
      end
      StPos:   state_d = StRead;
      StRead:  state_d = StAcc;
      StAcc:   state_d = StCheck;
      default: state_d = StIdle;
    endcase
    if (state_q == StMerge && !((dx_q == '0 && oxo) || (dy_q == '0 && oyo))) begin
      if (dx_q == '0 && dy_q == '0) begin
        state_d = StPos;
      end else if (!(ext_c < ent_c || ext_c < 0)) begin
        state_d = StCheck;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      size_q  <= 9'd256;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      done_q <= ((state_q == StMerge) || (state_q == StCheck)) && (state_d == StIdle);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        sz_q <= szc[8:0];
        ox_q <= origin_x_i; oy_q <= origin_y_i;
        dx_q <= dir_x_i;    dy_q <= dir_y_i;
        sidx_q <= '0;
        total_q <= '0;
      end
      StSlab: begin
        rem_q  <= '0;
        quo_q  <= nmag;
        dmag_q <= dmag;
        neg_q  <= num_a[NumBits-1] ^ dir_a[DirBits-1];
        dcnt_q <= 6'(NumBits-1);
      end
      StDiv: begin
        rem_q <= rnew[DirBits-1:0];
        quo_q <= {quo_q[NumBits-2:0], sub_ok};
        dcnt_q <= dcnt_q - 6'd1;
        if (dcnt_q == '0) begin
          // The last quotient bit joins here, ahead of the register update.
          tb_q[sidx_q] <= neg_q ? -$signed({1'b0, quo_q[NumBits-2:0], sub_ok})
                                :  $signed({1'b0, quo_q[NumBits-2:0], sub_ok});
          sidx_q <= sidx_q + 2'd1;
        end
      end
      StMerge: begin
        t_q    <= (ent_c > 0) ? ent_c : '0;
        exit_q <= ext_c;
        // A stationary ray reads its one cell once; the result saturates if it is nonzero.
        stat_q <= (dx_q == '0) && (dy_q == '0);
        res_q  <= '0;
        hit_q  <= !((dx_q == '0 && oxo) || (dy_q == '0 && oyo)) &&
                  ((dx_q == '0 && dy_q == '0) || !(ext_c < ent_c || ext_c < 0));
      end
      StPos: begin
        px_q <= (PosBits'(ox_q) <<< 14) + PosBits'(mx);
        py_q <= (PosBits'(oy_q) <<< 14) + PosBits'(my);
      end
      StRead: begin
        inb_q <= cin;
      end
      StAcc: begin
        total_q <= (sum > (TotalBits+1)'(TotalMax)) ? (TotalBits+1)'(TotalMax) : sum;
        t_q <= t_q + HalfStep;
      end
      StCheck: begin
        res_q <= stat_q ? ((total_q != '0) ? TotalMax : '0) : total_q[TotalBits-1:0];
        hit_q <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/rlip_checker.sv
// ----------------------------------------------------------------------------
// Ray line integral projector checker
// Port-level properties of the command and result interface.
// ----------------------------------------------------------------------------
module rlip_checker import rlip_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 command_i,
  input logic                 done_o,
  input logic [TotalBits-1:0] total_density_o,
  input logic                 ray_hit_o
);

  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == CmdWrite |=> !busy && !done_o) else $error("write busy");

  a_trace_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == CmdTrace |=> busy) else $error("trace not busy");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy)) else $error("stray result");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ray_hit_o |-> total_density_o == '0) else $error("miss nonzero");

endmodule

bind ray_line_integral_projector_core rlip_checker u_rlip_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .command_i(command_i), .done_o(done_o),
  .total_density_o(total_density_o), .ray_hit_o(ray_hit_o)
);
